/* src/gdbs_pkg.sv */
// shared types and constants for the guided dive branch select block
`timescale 1ns / 1ps
`default_nettype none

package gdbs_pkg;

  localparam int VALUE_BITS = 56;
  localparam int TOL_BITS   = 24;

  localparam logic [TOL_BITS-1:0] TOL_RESET = 24'd17;

  // non-binary variables get their score multiplied by this
  localparam int          PENALTY_BITS = 10;
  localparam logic [PENALTY_BITS-1:0] PENALTY = 10'd1000;

  // rounding direction codes, two's complement
  localparam logic [1:0] DIR_DOWN = 2'b11;
  localparam logic [1:0] DIR_UP   = 2'b01;

  // depth of the queue between classifier and selector, and of the result queue
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic frac_ok;
    logic both;
    logic last;
  } flags_t;

endpackage

`default_nettype wire

/* src/gdbs_fifo.sv */
// small first-in first-out queue with a count and wrap pointers
`timescale 1ns / 1ps
`default_nettype none

module gdbs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* src/gdbs_front.sv */
// classifier stage: tolerance register, fraction distance, direction and score
`timescale 1ns / 1ps
`default_nettype none

module gdbs_front #(
  parameter int COLUMN_BITS = 20,
  parameter int FRAC_BITS   = 24
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_write,
  input  wire logic [gdbs_pkg::TOL_BITS-1:0]          cfg_data,
  input  wire logic                                   push,
  output logic                                        full,
  input  wire logic signed [gdbs_pkg::VALUE_BITS-1:0] relaxed_value,
  input  wire logic signed [gdbs_pkg::VALUE_BITS-1:0] incumbent_value,
  input  wire logic [COLUMN_BITS-1:0]                 column,
  input  wire logic                                   is_binary,
  input  wire logic                                   down_locked,
  input  wire logic                                   up_locked,
  input  wire logic                                   last,
  output logic                                        q_push,
  input  wire logic                                   q_full,
  output logic [COLUMN_BITS-1:0]                      q_col,
  output logic [1:0]                                  q_dir,
  output logic [FRAC_BITS+9:0]                        q_score,
  output gdbs_pkg::flags_t                            q_flags
);

  localparam int SCORE_W = FRAC_BITS + 10;
  localparam int CMP_W   = (FRAC_BITS > gdbs_pkg::TOL_BITS) ? FRAC_BITS : gdbs_pkg::TOL_BITS;

  logic [gdbs_pkg::TOL_BITS-1:0] tolerance;
  logic                          f_valid;
  logic                          in_ready;
  logic                          accept;

  logic [FRAC_BITS-1:0] frac;
  logic [FRAC_BITS:0]   up_dist;
  logic [FRAC_BITS-1:0] near_dist;
  logic                 round_down;
  logic [FRAC_BITS:0]   raw_score;
  logic [SCORE_W-1:0]   score;
  gdbs_pkg::flags_t     flags;

  assign in_ready = !f_valid || !q_full;
  assign full     = !in_ready;
  assign accept   = push && in_ready;
  assign q_push   = f_valid;

  always_comb begin
    frac       = relaxed_value[FRAC_BITS-1:0];
    up_dist    = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
    // at or above one half the nearest integer is above
    near_dist  = frac[FRAC_BITS-1] ? up_dist[FRAC_BITS-1:0] : frac;
    round_down = (relaxed_value >= incumbent_value);
    raw_score  = round_down ? {1'b0, frac} : up_dist;
    if (is_binary) begin
      score = SCORE_W'(raw_score);
    end else begin
      score = SCORE_W'(raw_score) * SCORE_W'(gdbs_pkg::PENALTY);
    end
    flags.frac_ok = (CMP_W'(near_dist) > CMP_W'(tolerance));
    flags.both    = down_locked && up_locked;
    flags.last    = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= gdbs_pkg::TOL_RESET;
      f_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        tolerance <= cfg_data;
      end
      if (accept) begin
        f_valid <= 1'b1;
      end else if (!q_full) begin
        f_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_col   <= column;
      q_dir   <= round_down ? gdbs_pkg::DIR_DOWN : gdbs_pkg::DIR_UP;
      q_score <= score;
      q_flags <= flags;
    end
  end

endmodule

`default_nettype wire

/* src/gdbs_back.sv */
// selector stage: running minimum, lock-phase tracking and result hand-off
`timescale 1ns / 1ps
`default_nettype none

module gdbs_back #(
  parameter int COLUMN_BITS = 20,
  parameter int FRAC_BITS   = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_empty,
  output logic                        q_pop,
  input  wire logic [COLUMN_BITS-1:0] head_col,
  input  wire logic [1:0]             head_dir,
  input  wire logic [FRAC_BITS+9:0]   head_score,
  input  wire gdbs_pkg::flags_t       head_flags,
  input  wire logic                   out_full,
  output logic                        out_push,
  output logic [COLUMN_BITS:0]        out_col,
  output logic [1:0]                  out_dir,
  output logic                        out_roundable
);

  localparam int SCORE_W = FRAC_BITS + 10;

  logic [SCORE_W-1:0]   best_score;
  logic [COLUMN_BITS:0] best_col;
  logic [1:0]           best_dir;
  logic                 roundable;

  logic [SCORE_W-1:0]   best_score_next;
  logic [COLUMN_BITS:0] best_col_next;
  logic [1:0]           best_dir_next;
  logic                 roundable_next;
  logic                 consume;
  logic                 competes;
  logic                 clear_best;
  logic                 wins;
  logic [SCORE_W-1:0]   cur_best;

  assign consume  = !q_empty && (!head_flags.last || !out_full);
  assign q_pop    = consume;
  assign out_push = consume && head_flags.last;

  always_comb begin
    competes   = head_flags.frac_ok && (roundable || head_flags.both);
    // first doubly locked competitor restarts the search
    clear_best = competes && roundable && head_flags.both;
    cur_best   = clear_best ? '1 : best_score;
    wins       = competes && (head_score < cur_best);

    best_score_next = wins ? head_score : cur_best;
    best_col_next   = wins ? {1'b0, head_col} : best_col;
    best_dir_next   = wins ? head_dir : best_dir;
    roundable_next  = roundable && !clear_best;

    out_col       = best_col_next;
    out_dir       = best_dir_next;
    out_roundable = roundable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_score <= '1;
      best_col   <= '1;
      best_dir   <= gdbs_pkg::DIR_DOWN;
      roundable  <= 1'b1;
    end else if (consume) begin
      if (head_flags.last) begin
        best_score <= '1;
        best_col   <= '1;
        best_dir   <= gdbs_pkg::DIR_DOWN;
        roundable  <= 1'b1;
      end else begin
        best_score <= best_score_next;
        best_col   <= best_col_next;
        best_dir   <= best_dir_next;
        roundable  <= roundable_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_roundable_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(roundable) |-> $past(consume && head_flags.both && head_flags.frac_ok))
    else $error("roundable cleared without a locked fractional word");

  a_score_monotone: assert property (@(posedge clk) disable iff (rst)
    (consume && !head_flags.last && !roundable) |=> (best_score <= $past(best_score)))
    else $error("best score rose inside the locked phase");

  a_result_clears: assert property (@(posedge clk) disable iff (rst)
    out_push |=> (roundable && (best_score == '1)))
    else $error("scan state not cleared after a result");
`endif

endmodule

`default_nettype wire

/* src/guided_dive_branch_select.sv */
// Top level of the guided dive branch select block.
// Throughput: one word per cycle sustained; a stall on the result side backs up
// only once the result queue and the work queue are both full.
// Path: the result of a last word goes through the classifier register, then the work
// queue and the selector, into the result queue that drives the result ports.
// Reset: synchronous; tolerance returns to 17 and the scan state to no best.
`timescale 1ns / 1ps
`default_nettype none

module guided_dive_branch_select #(
  parameter int COLUMN_BITS = 20,
  parameter int FRAC_BITS   = 24
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_write,
  input  wire logic [gdbs_pkg::TOL_BITS-1:0]          cfg_data,
  input  wire logic                                   push,
  output logic                                        full,
  input  wire logic signed [gdbs_pkg::VALUE_BITS-1:0] relaxed_value,
  input  wire logic signed [gdbs_pkg::VALUE_BITS-1:0] incumbent_value,
  input  wire logic [COLUMN_BITS-1:0]                 column,
  input  wire logic                                   is_binary,
  input  wire logic                                   down_locked,
  input  wire logic                                   up_locked,
  input  wire logic                                   last,
  output logic                                        empty,
  input  wire logic                                   pop,
  output logic signed [COLUMN_BITS:0]                 best_column,
  output logic signed [1:0]                           best_direction,
  output logic                                        all_roundable
);

  localparam int SCORE_W = FRAC_BITS + 10;
  localparam int FLAGS_W = $bits(gdbs_pkg::flags_t);
  localparam int WORK_W  = FLAGS_W + COLUMN_BITS + 2 + SCORE_W;
  localparam int RES_W   = COLUMN_BITS + 1 + 2 + 1;

  logic                   f_push;
  logic                   f_full;
  logic [COLUMN_BITS-1:0] f_col;
  logic [1:0]             f_dir;
  logic [SCORE_W-1:0]     f_score;
  gdbs_pkg::flags_t       f_flags;

  logic [WORK_W-1:0]      work_in;
  logic [WORK_W-1:0]      work_out;
  logic                   work_empty;
  logic                   work_pop;

  logic                   r_push;
  logic                   r_full;
  logic [COLUMN_BITS:0]   r_col;
  logic [1:0]             r_dir;
  logic                   r_roundable;
  logic [RES_W-1:0]       res_out;

  gdbs_front #(
    .COLUMN_BITS(COLUMN_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .relaxed_value  (relaxed_value),
    .incumbent_value(incumbent_value),
    .column         (column),
    .is_binary      (is_binary),
    .down_locked    (down_locked),
    .up_locked      (up_locked),
    .last           (last),
    .q_push         (f_push),
    .q_full         (f_full),
    .q_col          (f_col),
    .q_dir          (f_dir),
    .q_score        (f_score),
    .q_flags        (f_flags)
  );

  assign work_in = {f_flags, f_col, f_dir, f_score};

  gdbs_fifo #(
    .WIDTH(WORK_W),
    .DEPTH(gdbs_pkg::QUEUE_DEPTH)
  ) u_work_q (
    .clk  (clk),
    .rst  (rst),
    .push (f_push),
    .wdata(work_in),
    .full (f_full),
    .pop  (work_pop),
    .rdata(work_out),
    .empty(work_empty)
  );

  gdbs_back #(
    .COLUMN_BITS(COLUMN_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (work_empty),
    .q_pop        (work_pop),
    .head_col     (work_out[SCORE_W+2 +: COLUMN_BITS]),
    .head_dir     (work_out[SCORE_W +: 2]),
    .head_score   (work_out[SCORE_W-1:0]),
    .head_flags   (gdbs_pkg::flags_t'(work_out[WORK_W-1 -: FLAGS_W])),
    .out_full     (r_full),
    .out_push     (r_push),
    .out_col      (r_col),
    .out_dir      (r_dir),
    .out_roundable(r_roundable)
  );

  gdbs_fifo #(
    .WIDTH(RES_W),
    .DEPTH(gdbs_pkg::QUEUE_DEPTH)
  ) u_result_q (
    .clk  (clk),
    .rst  (rst),
    .push (r_push),
    .wdata({r_col, r_dir, r_roundable}),
    .full (r_full),
    .pop  (pop),
    .rdata(res_out),
    .empty(empty)
  );

  assign best_column    = res_out[RES_W-1 -: COLUMN_BITS+1];
  assign best_direction = res_out[2:1];
  assign all_roundable  = res_out[0];

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the guided dive branch select block
`timescale 1ns / 1ps

module testbench;

  localparam int COLUMN_BITS = 20;
  localparam int FRAC_BITS   = 24;
  localparam int SCORE_BITS  = FRAC_BITS + 10;
  localparam int VBITS       = gdbs_pkg::VALUE_BITS;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE      = 10;

  localparam logic signed [VBITS-1:0] ONE  = 56'sh1000000;
  localparam logic signed [VBITS-1:0] QTR  = 56'sh400000;
  localparam logic signed [VBITS-1:0] HALF = 56'sh800000;
  localparam logic signed [VBITS-1:0] VMAX = 56'sh7FFFFFFFFFFFFF;
  localparam logic signed [VBITS-1:0] VMIN = 56'sh80000000000000;
  localparam logic [gdbs_pkg::TOL_BITS-1:0] TOL_HALF = 24'h800000;

  typedef struct packed {
    logic signed [VBITS-1:0] rv;
    logic signed [VBITS-1:0] iv;
    logic [COLUMN_BITS-1:0]  col;
    logic                    bin;
    logic                    dl;
    logic                    ul;
    logic                    lst;
  } var_word_t;

  typedef struct packed {
    logic signed [COLUMN_BITS:0] col;
    logic signed [1:0]           dir;
    logic                        roundable;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [gdbs_pkg::TOL_BITS-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic signed [VBITS-1:0] relaxed_value = '0;
  logic signed [VBITS-1:0] incumbent_value = '0;
  logic [COLUMN_BITS-1:0] column = '0;
  logic is_binary = 1'b0;
  logic down_locked = 1'b0;
  logic up_locked = 1'b0;
  logic last = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [COLUMN_BITS:0] best_column;
  logic signed [1:0] best_direction;
  logic all_roundable;

  guided_dive_branch_select #(
    .COLUMN_BITS(COLUMN_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .relaxed_value(relaxed_value),
    .incumbent_value(incumbent_value),
    .column(column),
    .is_binary(is_binary),
    .down_locked(down_locked),
    .up_locked(up_locked),
    .last(last),
    .empty(empty),
    .pop(pop),
    .best_column(best_column),
    .best_direction(best_direction),
    .all_roundable(all_roundable)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // selector model state
  logic [gdbs_pkg::TOL_BITS-1:0] tol_model = gdbs_pkg::TOL_RESET;
  logic [SCORE_BITS-1:0]         sel_score = '1;
  logic signed [COLUMN_BITS:0]   sel_col = '1;
  logic signed [1:0]             sel_dir = gdbs_pkg::DIR_DOWN;
  logic                          sel_roundable = 1'b1;
  pick_t                         pick_q[$];

  int errors = 0;
  int words_sent = 0;
  int scans_done = 0;
  int lock_clears = 0;
  int tol_writes = 0;
  int full_stalls = 0;
  int idle_cycles = 0;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit hold_req = 1'b0;

  task automatic scan_word(input var_word_t w);
    logic [FRAC_BITS-1:0]  frac;
    logic [FRAC_BITS:0]    off_int;
    logic [SCORE_BITS-1:0] score;
    logic signed [1:0]     dir;
    logic                  both;
    frac = w.rv[FRAC_BITS-1:0];
    off_int = frac[FRAC_BITS-1] ? ((25'd1 << FRAC_BITS) - frac) : {1'b0, frac};
    both = w.dl && w.ul;
    if (off_int > {1'b0, tol_model} && (sel_roundable || both)) begin
      if (sel_roundable && both) begin
        sel_roundable = 1'b0;
        sel_score = '1;
        lock_clears++;
      end
      if (w.rv >= w.iv) begin
        dir = gdbs_pkg::DIR_DOWN;
        score = SCORE_BITS'(frac);
      end else begin
        dir = gdbs_pkg::DIR_UP;
        score = (SCORE_BITS'(1) << FRAC_BITS) - SCORE_BITS'(frac);
      end
      if (!w.bin) score = score * SCORE_BITS'(gdbs_pkg::PENALTY);
      if (score < sel_score) begin
        sel_score = score;
        sel_col = {1'b0, w.col};
        sel_dir = dir;
      end
    end
    if (w.lst) begin
      pick_q.push_back('{col: sel_col, dir: sel_dir, roundable: sel_roundable});
      scans_done++;
      sel_score = '1;
      sel_col = '1;
      sel_dir = gdbs_pkg::DIR_DOWN;
      sel_roundable = 1'b1;
    end
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // offer one word and hold it until taken
  task automatic send_word(input var_word_t w);
    int gap;
    push <= 1'b1;
    relaxed_value <= w.rv;
    incumbent_value <= w.iv;
    column <= w.col;
    is_binary <= w.bin;
    down_locked <= w.dl;
    up_locked <= w.ul;
    last <= w.lst;
    @(posedge clk);
    while (full) @(posedge clk);
    scan_word(w);
    words_sent++;
    gap = tx_gaps ? rand_gap() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pick_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_tolerance(input logic [gdbs_pkg::TOL_BITS-1:0] v);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    tol_model = v;
    tol_writes++;
  endtask

  function automatic var_word_t mk(input logic signed [VBITS-1:0] rv,
                                   input logic signed [VBITS-1:0] iv,
                                   input logic [COLUMN_BITS-1:0] col,
                                   input logic bin, input logic dl,
                                   input logic ul, input logic lst);
    var_word_t w;
    w = '{rv: rv, iv: iv, col: col, bin: bin, dl: dl, ul: ul, lst: lst};
    return w;
  endfunction

  // fractions clustered around the tolerance edges and the half point
  function automatic logic [FRAC_BITS-1:0] pick_frac();
    logic [FRAC_BITS-1:0] t;
    t = tol_model;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return t;
      2: return t + 24'd1;
      3: return 24'd0 - t;
      4: return 24'd0 - t - 24'd1;
      5: return 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic var_word_t rand_word(input logic lst, input int lock_pct);
    var_word_t w;
    logic [31:0] ipart;
    logic signed [VBITS-1:0] delta;
    if ($urandom_range(0, 3) == 0) ipart = $urandom;
    else ipart = 32'($signed($urandom_range(0, 2000)) - 1000);
    w.rv = {ipart, pick_frac()};
    if ($urandom_range(0, 9) == 0) w.rv = {$urandom, 24'($urandom)};
    delta = VBITS'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
    case ($urandom_range(0, 3))
      0: w.iv = w.rv;
      1: w.iv = w.rv + delta;
      2: w.iv = {w.rv[VBITS-1:FRAC_BITS], pick_frac()};
      default: w.iv = {$urandom, 24'($urandom)};
    endcase
    w.col = COLUMN_BITS'($urandom);
    w.bin = 1'($urandom_range(0, 1));
    w.dl = ($urandom_range(0, 99) < lock_pct);
    w.ul = ($urandom_range(0, 99) < lock_pct);
    w.lst = lst;
    return w;
  endfunction

  // mostly short scans, now and then a long one
  task automatic random_scans(input int n_words, input int lock_pct);
    int sent;
    int len;
    sent = 0;
    while (sent < n_words) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        send_word(rand_word(i == len - 1, lock_pct));
      end
      sent += len;
    end
  endtask

  task automatic test_no_competitor();
    send_word(mk(5 * ONE, 5 * ONE, 20'd1, 1, 0, 0, 1));
    send_word(mk(3 * ONE + 17, 0, 20'd2, 1, 0, 0, 0));
    send_word(mk(3 * ONE - 17, 0, 20'd3, 1, 0, 0, 0));
    send_word(mk(-2 * ONE + 18, -10 * ONE, 20'd4, 1, 0, 0, 1));
  endtask

  task automatic test_direction_penalty();
    send_word(mk(ONE + QTR, ONE + QTR, 20'd10, 1, 0, 0, 0));
    send_word(mk(2 * ONE + QTR, 7 * ONE, 20'd11, 1, 0, 0, 0));
    send_word(mk(7 * ONE + QTR, 0, 20'd12, 1, 0, 0, 0));
    send_word(mk(HALF, ONE, 20'd13, 1, 0, 0, 0));
    send_word(mk(ONE + 100, 0, 20'd14, 0, 0, 0, 0));
    send_word(mk(-ONE - 100, 0, 20'd15, 0, 0, 0, 1));
    // exact half both ways, earliest keeps the tie
    send_word(mk(3 * ONE + HALF, 3 * ONE + HALF, 20'd16, 1, 0, 0, 0));
    send_word(mk(2 * ONE + HALF, 5 * ONE, 20'd17, 1, 0, 0, 1));
  endtask

  task automatic test_lock_clear();
    send_word(mk(ONE + 100, ONE + 100, 20'd20, 1, 0, 0, 0));
    send_word(mk(ONE + QTR, 0, 20'd21, 1, 1, 0, 0));
    send_word(mk(ONE + HALF, 0, 20'd22, 0, 1, 1, 0));
    send_word(mk(ONE + 50, 0, 20'd23, 1, 0, 0, 0));
    send_word(mk(ONE + QTR, 0, 20'd24, 0, 1, 1, 0));
    send_word(mk(5 * ONE, 0, 20'd25, 1, 1, 1, 1));
    send_word(mk(ONE + QTR, 0, 20'd26, 1, 0, 0, 0));
    send_word(mk(2 * ONE - 5, 9 * ONE, 20'd27, 1, 1, 1, 1));
  endtask

  task automatic test_extremes();
    send_word(mk(VMAX, VMIN, 20'hFFFFF, 1, 0, 0, 0));
    send_word(mk(VMIN + QTR, VMAX, 20'hFFFFF, 1, 1, 0, 0));
    send_word(mk(VMIN, VMAX, 20'h00000, 0, 0, 1, 1));
    send_word(mk(QTR, -ONE, 20'h00000, 0, 1, 1, 1));
  endtask

  task automatic test_tolerance_sweep();
    set_tolerance(gdbs_pkg::TOL_RESET);
    random_scans(150, 30);
    set_tolerance('0);
    random_scans(100, 20);
    // at one half nothing can compete
    set_tolerance(TOL_HALF);
    random_scans(60, 30);
    set_tolerance(TOL_HALF - 24'd1);
    random_scans(60, 30);
    set_tolerance(24'($urandom_range(0, 1 << 20)));
    random_scans(120, 50);
  endtask

  task automatic test_back_to_back();
    set_tolerance(24'($urandom_range(0, TOL_HALF)));
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    random_scans(100, 25);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // receiver holds off while every word closes a scan, so the block backs up
  task automatic test_result_backpressure();
    set_tolerance(24'($urandom_range(0, 1 << 16)));
    tx_gaps = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) send_word(rand_word(1'b1, 40));
    tx_gaps = 1'b1;
  endtask

  // result side: pops with random stalls, plus the long hold-off on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        if (rx_gaps) stall = rand_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    pick_t want;
    if (!rst && pop && !empty) begin
      if (pick_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: col %0d dir %0d roundable %0b",
                   best_column, best_direction, all_roundable);
      end else begin
        want = pick_q.pop_front();
        if (best_column !== want.col || best_direction !== want.dir ||
            all_roundable !== want.roundable) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp col %0d dir %0d roundable %0b, got col %0d dir %0d roundable %0b",
                     want.col, want.dir, want.roundable,
                     best_column, best_direction, all_roundable);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (push && full) full_stalls <= full_stalls + 1;
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_no_competitor();
    test_direction_penalty();
    test_lock_clear();
    test_extremes();
    test_tolerance_sweep();
    test_back_to_back();
    test_result_backpressure();
    set_tolerance(24'($urandom_range(0, TOL_HALF)));
    random_scans(100, 35);
    wait_idle();
    $display("covered %0d words in %0d scans, %0d lock-both clears, %0d tolerance writes",
             words_sent, scans_done, lock_clears, tol_writes);
    $display("input held off by full for %0d cycles, %0d mismatches", full_stalls, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
src/gdbs_pkg.sv
src/gdbs_fifo.sv
src/gdbs_front.sv
src/gdbs_back.sv
src/guided_dive_branch_select.sv
tb/testbench.sv
